[rtl/opme_pkg.sv]
// Package with widths, state encoding and shared types for the oriented point match error block.
`default_nettype none
package opme_pkg;

    localparam int WORD_W   = 16;
    localparam int VEC3_W   = 48;
    localparam int VEC2_W   = 32;
    localparam int K_W      = 16;
    localparam int MINN_W   = 14;
    localparam int ERR_W    = 32;
    localparam int TOT_W    = 48;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    // Shared multiplier operand and product widths.
    localparam int MA_W     = 36;
    localparam int MB_W     = 19;
    localparam int MP_W     = MA_W + MB_W;
    localparam int ACC_W    = 58;

    // Square root and divide unit.
    localparam int SD_W     = 54;
    localparam int SQRT_IT  = 27;
    localparam int DIV_IT   = 18;
    localparam int SDCNT_W  = 5;
    localparam int NUM_W    = 45;
    localparam int DEN_W    = 28;
    localparam int ROOT_W   = 27;
    localparam int QUOT_W   = 18;

    localparam int N2_W     = 38;
    localparam int STEP_W   = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd24;

    localparam logic [MINN_W-1:0] MIN_NORM_RST = 14'd16;
    localparam logic [CFG_AW-1:0] REG_MIN_NORM = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SQRT,
        ST_DIV,
        ST_KMUL,
        ST_KACC,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic div_mode;
    } t_sd_req;

    typedef struct packed {
        logic done;
    } t_sd_sts;

    function automatic logic signed [WORD_W-1:0] word16(input logic [VEC3_W-1:0] v,
                                                       input logic [1:0] idx);
        logic signed [WORD_W-1:0] w;
        w = v[idx*WORD_W +: WORD_W];
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/opme_if.sv]
// Stream interfaces for the sample pair input and the error result output.
`default_nettype none
interface opme_in_if;
    import opme_pkg::*;
    logic                valid;
    logic                ready;
    logic [VEC3_W-1:0]   source_point;
    logic [VEC2_W-1:0]   source_dir_2d;
    logic [VEC3_W-1:0]   target_point;
    logic [VEC3_W-1:0]   target_dir;
    logic [VEC3_W-1:0]   plane_rot_col0;
    logic [VEC3_W-1:0]   plane_rot_col1;
    logic [K_W-1:0]      concentration;
    logic [VEC3_W-1:0]   inv_cov_diag;
    logic [VEC3_W-1:0]   inv_cov_offdiag;
    logic                first_sample;

    modport source(output valid, source_point, source_dir_2d, target_point, target_dir,
                   plane_rot_col0, plane_rot_col1, concentration, inv_cov_diag,
                   inv_cov_offdiag, first_sample, input ready);
    modport sink(input valid, source_point, source_dir_2d, target_point, target_dir,
                 plane_rot_col0, plane_rot_col1, concentration, inv_cov_diag,
                 inv_cov_offdiag, first_sample, output ready);
endinterface

interface opme_out_if;
    import opme_pkg::*;
    logic               valid;
    logic               ready;
    logic [ERR_W-1:0]   sample_error;
    logic [TOT_W-1:0]   total_error;
    logic               dir_degenerate;

    modport source(output valid, sample_error, total_error, dir_degenerate, input ready);
    modport sink(input valid, sample_error, total_error, dir_degenerate, output ready);
endinterface
`default_nettype wire

[rtl/opme_cfg.sv]
// APB register holding the degeneracy threshold.
`default_nettype none
module opme_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [opme_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [opme_pkg::CFG_DW-1:0]   pwdata,
    output logic      [opme_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready,
    output logic      [opme_pkg::MINN_W-1:0]   o_min_norm
);
    import opme_pkg::*;

    logic [MINN_W-1:0] r_min_norm;
    logic              hit;

    // The register occupies the first word; the low address bits are ignored.
    assign hit = (paddr[CFG_AW-1:2] == REG_MIN_NORM[CFG_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_norm <= MIN_NORM_RST;
        end else if (psel && penable && pwrite && hit) begin
            r_min_norm <= pwdata[MINN_W-1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = hit ? {{(CFG_DW-MINN_W){1'b0}}, r_min_norm} : '0;
    assign o_min_norm = r_min_norm;
endmodule
`default_nettype wire

[rtl/opme_sqdiv.sv]
// Iterative square root and restoring divider sharing one subtractor.
`default_nettype none
module opme_sqdiv (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire opme_pkg::t_sd_req             i_req,
    input  wire logic [opme_pkg::SD_W-1:0]     i_rad,
    input  wire logic [opme_pkg::NUM_W-1:0]    i_num,
    input  wire logic [opme_pkg::DEN_W-1:0]    i_den,
    output opme_pkg::t_sd_sts                  o_sts,
    output logic      [opme_pkg::ROOT_W-1:0]   o_root,
    output logic      [opme_pkg::QUOT_W-1:0]   o_quot
);
    import opme_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_mode;
    logic [SDCNT_W-1:0]   r_cnt;
    logic [SD_W-1:0]      r_rem;
    logic [SD_W-1:0]      r_op;
    logic [SD_W-1:0]      r_res;
    logic [SD_W:0]        sub;
    logic [SD_W:0]        trial;
    logic                 ge;

    // Square root compares against root plus the current bit; divide against
    // the shifted divisor.
    assign sub   = r_mode ? {1'b0, r_op} : ({1'b0, r_res} + {1'b0, r_op});
    assign trial = {1'b0, r_rem} - sub;
    assign ge    = !trial[SD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.div_mode ? SDCNT_W'(DIV_IT) : SDCNT_W'(SQRT_IT);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SDCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.div_mode;
            r_res  <= '0;
            if (i_req.div_mode) begin
                r_rem <= SD_W'(i_num);
                r_op  <= SD_W'(i_den) << (DIV_IT - 1);
            end else begin
                r_rem <= i_rad;
                r_op  <= SD_W'(1) << (2 * (SQRT_IT - 1));
            end
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= trial[SD_W-1:0];
            end
            if (r_mode) begin
                r_res <= {r_res[SD_W-2:0], ge};
                r_op  <= r_op >> 1;
            end else begin
                r_res <= ge ? ((r_res >> 1) + r_op) : (r_res >> 1);
                r_op  <= r_op >> 2;
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_root     = r_res[ROOT_W-1:0];
    assign o_quot     = r_res[QUOT_W-1:0];
endmodule
`default_nettype wire

[rtl/oriented_point_match_error.sv]
// Top level of the oriented point match error block with its running total.
// When the projected direction is degenerate, the root and divide are skipped.
// Throughput: one item at a time; the next transfer is taken once the result has left.
// The processing time is set by the shared multiplier (25 steps), the bit-serial root and the divider.
// Reset is synchronous, active low; it clears the running total and sets the threshold to 16.
`default_nettype none
module oriented_point_match_error (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    opme_in_if.sink                            i_in,
    opme_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [opme_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [opme_pkg::CFG_DW-1:0]   pwdata,
    output logic      [opme_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready
);
    import opme_pkg::*;

    // Control state.
    t_state             r_state;
    t_state             n_state;
    logic [STEP_W-1:0]  r_step;
    logic [TOT_W-1:0]   r_run;

    // Item payload, captured at the input transfer.
    logic [VEC2_W-1:0]  r_sdir;
    logic [VEC3_W-1:0]  r_tdir;
    logic [VEC3_W-1:0]  r_col0;
    logic [VEC3_W-1:0]  r_col1;
    logic [K_W-1:0]     r_k;
    logic [VEC3_W-1:0]  r_mdiag;
    logic [VEC3_W-1:0]  r_moff;
    logic               r_first;
    logic signed [WORD_W:0] r_d [3];

    // Datapath registers.
    logic signed [MP_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [MB_W-1:0]   r_q0;
    logic signed [MB_W-1:0]   r_q1;
    logic [N2_W-1:0]          r_n2;
    logic signed [MA_W-1:0]   r_dn;
    logic signed [MB_W-1:0]   r_dot;
    logic                     r_degen;
    logic [ERR_W-1:0]         r_err;
    logic [TOT_W-1:0]         r_tot;

    logic [MINN_W-1:0]        min_norm;
    t_sd_req                  sd_req;
    t_sd_sts                  sd_sts;
    logic [ROOT_W-1:0]        sd_root;
    logic [QUOT_W-1:0]        sd_quot;
    logic [SD_W-1:0]          sd_rad;
    logic [NUM_W-1:0]         sd_num;
    logic [DEN_W-1:0]         sd_den;
    logic [MA_W-1:0]          dn_mag;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  p_ext;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic                     degen_now;
    logic signed [ACC_W-1:0]  err_rnd;
    logic [ERR_W-1:0]         err_sat;
    logic [TOT_W:0]           tot_sum;

    opme_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_min_norm (min_norm)
    );

    // The root takes (q0^2 + q1^2) scaled by 2^16, giving the norm in Q.22. The
    // divide takes 2|a| + b over 2b, which rounds a / b to nearest with halves
    // away from zero.
    assign dn_mag = r_dn[MA_W-1] ? MA_W'(-r_dn) : MA_W'(r_dn);
    assign sd_rad = {r_n2, 16'd0};
    assign sd_num = NUM_W'({dn_mag, 9'd0}) + NUM_W'(sd_root);
    assign sd_den = {sd_root, 1'b0};

    opme_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sd_req),
        .i_rad   (sd_rad),
        .i_num   (sd_num),
        .i_den   (sd_den),
        .o_sts   (sd_sts),
        .o_root  (sd_root),
        .o_quot  (sd_quot)
    );

    // Operand selection for the shared multiplier. The projection dot
    // products come first, then |q|^2 and q.s, then the quadratic form, where
    // each product of two offsets is fed back from the product register and
    // multiplied by its inverse covariance entry. The last step squares the
    // threshold for the degeneracy test.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_KMUL) begin
            mul_a = MA_W'(r_k);
            mul_b = MB_W'(16384) - r_dot;
        end else begin
            case (r_step)
                5'd0:  begin mul_a = MA_W'(word16(r_col0, 2'd0)); mul_b = MB_W'(word16(r_tdir, 2'd0)); end
                5'd1:  begin mul_a = MA_W'(word16(r_col0, 2'd1)); mul_b = MB_W'(word16(r_tdir, 2'd1)); end
                5'd2:  begin mul_a = MA_W'(word16(r_col0, 2'd2)); mul_b = MB_W'(word16(r_tdir, 2'd2)); end
                5'd3:  begin mul_a = MA_W'(word16(r_col1, 2'd0)); mul_b = MB_W'(word16(r_tdir, 2'd0)); end
                5'd4:  begin mul_a = MA_W'(word16(r_col1, 2'd1)); mul_b = MB_W'(word16(r_tdir, 2'd1)); end
                5'd5:  begin mul_a = MA_W'(word16(r_col1, 2'd2)); mul_b = MB_W'(word16(r_tdir, 2'd2)); end
                5'd7:  begin mul_a = MA_W'(r_q0); mul_b = r_q0; end
                5'd8:  begin mul_a = MA_W'(r_q1); mul_b = r_q1; end
                5'd9:  begin mul_a = MA_W'(r_q0); mul_b = MB_W'(word16(VEC3_W'(r_sdir), 2'd0)); end
                5'd10: begin mul_a = MA_W'(r_q1); mul_b = MB_W'(word16(VEC3_W'(r_sdir), 2'd1)); end
                5'd11: begin mul_a = MA_W'(r_d[0]); mul_b = MB_W'(r_d[0]); end
                5'd12: begin mul_a = r_prod[MA_W-1:0]; mul_b = MB_W'(word16(r_mdiag, 2'd0)); end
                5'd13: begin mul_a = MA_W'(r_d[1]); mul_b = MB_W'(r_d[1]); end
                5'd14: begin mul_a = r_prod[MA_W-1:0]; mul_b = MB_W'(word16(r_mdiag, 2'd1)); end
                5'd15: begin mul_a = MA_W'(r_d[2]); mul_b = MB_W'(r_d[2]); end
                5'd16: begin mul_a = r_prod[MA_W-1:0]; mul_b = MB_W'(word16(r_mdiag, 2'd2)); end
                5'd17: begin mul_a = MA_W'(r_d[0]); mul_b = MB_W'(r_d[1]); end
                5'd18: begin mul_a = r_prod[MA_W-1:0]; mul_b = MB_W'(word16(r_moff, 2'd0)); end
                5'd19: begin mul_a = MA_W'(r_d[0]); mul_b = MB_W'(r_d[2]); end
                5'd20: begin mul_a = r_prod[MA_W-1:0]; mul_b = MB_W'(word16(r_moff, 2'd1)); end
                5'd21: begin mul_a = MA_W'(r_d[1]); mul_b = MB_W'(r_d[2]); end
                5'd22: begin mul_a = r_prod[MA_W-1:0]; mul_b = MB_W'(word16(r_moff, 2'd2)); end
                5'd23: begin mul_a = MA_W'(min_norm); mul_b = MB_W'(min_norm); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign p_ext   = ACC_W'(r_prod);
    // Rounding to Q.14 with halves toward plus infinity.
    assign acc_rnd = (r_acc + ACC_W'(8192)) >>> 14;
    // A zero projection is always degenerate, whatever the threshold.
    assign degen_now = (r_n2 == '0) || (r_n2 < r_prod[N2_W-1:0]);

    // Final rounding from Q.22 to Q16.16; a sum that is not positive clamps to zero.
    assign err_rnd = (r_acc + ACC_W'(32)) >>> 6;
    always_comb begin
        if (r_acc <= 0) begin
            err_sat = '0;
        end else if (err_rnd > ACC_W'({ERR_W{1'b1}})) begin
            err_sat = '1;
        end else begin
            err_sat = err_rnd[ERR_W-1:0];
        end
    end
    assign tot_sum = (r_first ? (TOT_W+1)'(0) : {1'b0, r_run}) + (TOT_W+1)'(err_sat);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_MAC;
            ST_MAC: begin
                if (r_step == STEP_LAST) begin
                    n_state = degen_now ? ST_KMUL : ST_SQRT;
                end
            end
            ST_SQRT: if (sd_sts.done) n_state = ST_DIV;
            ST_DIV:  if (sd_sts.done) n_state = ST_KMUL;
            ST_KMUL: n_state = ST_KACC;
            ST_KACC: n_state = ST_FIN;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake and unit control.
    always_comb begin
        i_in.ready      = 1'b0;
        o_out.valid     = 1'b0;
        sd_req.start    = 1'b0;
        sd_req.div_mode = 1'b0;
        unique case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_MAC:  sd_req.start = (r_step == STEP_LAST) && !degen_now;
            ST_SQRT: begin
                sd_req.start    = sd_sts.done;
                sd_req.div_mode = 1'b1;
            end
            ST_OUT:  o_out.valid = 1'b1;
            default: ;
        endcase
    end

    // The running total takes the new sum while the result waits in the output
    // register, so it is current before the next item is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_run   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MAC) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (r_state == ST_OUT) begin
                r_run <= r_tot;
            end
        end
    end

    // Datapath. Within the step sequence, the accumulator acts on the product
    // of the previous step. The quadratic form is built as twice its value:
    // diagonal terms enter doubled and off-diagonal terms times four.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_IDLE: begin
                r_sdir  <= i_in.source_dir_2d;
                r_tdir  <= i_in.target_dir;
                r_col0  <= i_in.plane_rot_col0;
                r_col1  <= i_in.plane_rot_col1;
                r_k     <= i_in.concentration;
                r_mdiag <= i_in.inv_cov_diag;
                r_moff  <= i_in.inv_cov_offdiag;
                r_first <= i_in.first_sample;
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= (WORD_W+1)'(word16(i_in.target_point, 2'(i)))
                            - (WORD_W+1)'(word16(i_in.source_point, 2'(i)));
                end
            end
            ST_MAC: begin
                case (r_step)
                    5'd1, 5'd8: r_acc <= p_ext;
                    5'd2, 5'd3, 5'd5, 5'd6, 5'd9, 5'd11: r_acc <= r_acc + p_ext;
                    5'd4: begin
                        r_q0  <= acc_rnd[MB_W-1:0];
                        r_acc <= p_ext;
                    end
                    5'd7: r_q1 <= acc_rnd[MB_W-1:0];
                    5'd10: begin
                        r_n2  <= r_acc[N2_W-1:0];
                        r_acc <= p_ext;
                    end
                    5'd12: r_dn <= r_acc[MA_W-1:0];
                    5'd13: r_acc <= p_ext <<< 1;
                    5'd15, 5'd17: r_acc <= r_acc + (p_ext <<< 1);
                    5'd19, 5'd21, 5'd23: r_acc <= r_acc + (p_ext <<< 2);
                    5'd24: begin
                        r_degen <= degen_now;
                        r_dot   <= '0;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                if (sd_sts.done) begin
                    r_dot <= r_dn[MA_W-1] ? -MB_W'(sd_quot) : MB_W'(sd_quot);
                end
            end
            ST_KACC: r_acc <= r_acc + p_ext;
            ST_FIN: begin
                r_err <= err_sat;
                r_tot <= tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_out.sample_error   = r_err;
    assign o_out.total_error    = r_tot;
    assign o_out.dir_degenerate = r_degen;
endmodule
`default_nettype wire

[tb/opme_tb_if.sv]
// Testbench-side helper package: nothing here beyond the item type for the stimulus table and the result type.
`timescale 1ns / 1ps
package opme_tb_pkg;
    import opme_pkg::*;

    typedef struct packed {
        logic [VEC3_W-1:0] source_point;
        logic [VEC2_W-1:0] source_dir_2d;
        logic [VEC3_W-1:0] target_point;
        logic [VEC3_W-1:0] target_dir;
        logic [VEC3_W-1:0] plane_rot_col0;
        logic [VEC3_W-1:0] plane_rot_col1;
        logic [K_W-1:0]    concentration;
        logic [VEC3_W-1:0] inv_cov_diag;
        logic [VEC3_W-1:0] inv_cov_offdiag;
        logic              first_sample;
    } t_pair;

    typedef struct packed {
        logic [ERR_W-1:0] sample_error;
        logic [TOT_W-1:0] total_error;
        logic             dir_degenerate;
    } t_match_err;
endpackage

[tb/tb.sv]
// Self-checking testbench for the oriented point match error block.
`timescale 1ns / 1ps
module tb;
    import opme_pkg::*;
    import opme_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    opme_in_if  pair_bus();
    opme_out_if err_bus();

    oriented_point_match_error uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(pair_bus), .o_out(err_bus),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The predictor keeps its own copy of the threshold and the running total.
    logic [MINN_W-1:0] pred_min_norm;
    logic [TOT_W-1:0]  pred_total;
    t_match_err        expected_errs[$];
    int                fail_count;
    int                rx_stall_pct;   // Receiver idling, in percent.
    int                tx_stall_pct;   // Sender idling, in percent.
    int                hold_cycles;    // Long receiver hold-off, counted below.

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous fixed limit for about 1400 items plus stalls.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [63:0] sword(input logic [VEC3_W-1:0] v, input int idx);
        return 64'(signed'(v[idx*16 +: 16]));
    endfunction

    // Rounds a Q.28 value to Q.14 with halves toward plus infinity.
    function automatic logic signed [63:0] round_to_q14(input logic signed [63:0] v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv, rem;
        root = 0;
        rem  = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Works out one result and advances the predicted running total.
    function automatic t_match_err predict_match_err(input t_pair p);
        logic signed [63:0] dvec[3];
        logic signed [63:0] proj0, proj1, q0, q1, dot, quad, sum22, s0, s1;
        logic signed [63:0] numer, mag;
        logic [63:0] n2, nrm, err, total;
        logic degen;
        t_match_err r;
        proj0 = 0;
        proj1 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            dvec[i] = sword(p.target_point, i) - sword(p.source_point, i);
            proj0 += sword(p.plane_rot_col0, i) * sword(p.target_dir, i);
            proj1 += sword(p.plane_rot_col1, i) * sword(p.target_dir, i);
        end
        q0 = round_to_q14(proj0);
        q1 = round_to_q14(proj1);
        n2 = q0 * q0 + q1 * q1;
        degen = (n2 == 0) || (n2 < 64'(pred_min_norm) * 64'(pred_min_norm));
        if (!degen) begin
            s0 = sword(48'(p.source_dir_2d), 0);
            s1 = sword(48'(p.source_dir_2d), 1);
            nrm = int_sqrt(n2 << 16);
            numer = (q0 * s0 + q1 * s1) * 256;
            mag = (numer < 0) ? -numer : numer;
            dot = (2 * mag + nrm) / (2 * nrm);
            if (numer < 0) dot = -dot;
        end
        quad = sword(p.inv_cov_diag, 0) * dvec[0] * dvec[0]
             + sword(p.inv_cov_diag, 1) * dvec[1] * dvec[1]
             + sword(p.inv_cov_diag, 2) * dvec[2] * dvec[2]
             + 2 * (sword(p.inv_cov_offdiag, 0) * dvec[0] * dvec[1]
                  + sword(p.inv_cov_offdiag, 1) * dvec[0] * dvec[2]
                  + sword(p.inv_cov_offdiag, 2) * dvec[1] * dvec[2]);
        sum22 = 64'(p.concentration) * (64'sd16384 - dot) + 2 * quad;
        if (sum22 <= 0) begin
            err = 0;
        end else begin
            err = (64'(sum22) + 64'd32) >> 6;
            if (err > 64'hFFFF_FFFF) err = 64'hFFFF_FFFF;
        end
        if (p.first_sample) pred_total = '0;
        total = 64'(pred_total) + err;
        if (total > 64'hFFFF_FFFF_FFFF) total = 64'hFFFF_FFFF_FFFF;
        pred_total = total[TOT_W-1:0];
        r.sample_error   = err[ERR_W-1:0];
        r.total_error    = pred_total;
        r.dir_degenerate = degen;
        return r;
    endfunction

    // Register write through the APB-style port: setup cycle, then access cycle.
    task automatic write_min_norm(input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MIN_NORM;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pred_min_norm = value[MINN_W-1:0];
    endtask

    // Writes to an unused register index must be ignored by the block.
    task automatic write_unused(input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd4;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one pair, with random idling before it, and waits for its transfer.
    task automatic send_pair(input t_pair p);
        while ($urandom_range(99) < tx_stall_pct) begin
            pair_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_bus.valid           <= 1'b1;
        pair_bus.source_point    <= p.source_point;
        pair_bus.source_dir_2d   <= p.source_dir_2d;
        pair_bus.target_point    <= p.target_point;
        pair_bus.target_dir      <= p.target_dir;
        pair_bus.plane_rot_col0  <= p.plane_rot_col0;
        pair_bus.plane_rot_col1  <= p.plane_rot_col1;
        pair_bus.concentration   <= p.concentration;
        pair_bus.inv_cov_diag    <= p.inv_cov_diag;
        pair_bus.inv_cov_offdiag <= p.inv_cov_offdiag;
        pair_bus.first_sample    <= p.first_sample;
        @(posedge i_clk);
        while (!pair_bus.ready) @(posedge i_clk);
        expected_errs.push_back(predict_match_err(p));
    endtask

    task automatic drop_valid();
        pair_bus.valid <= 1'b0;
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain_results();
        while (expected_errs.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [15:0] q14(input real v);
        return 16'($rtoi(v * 16384.0));
    endfunction

    // Mostly realistic geometry: small positions, unit-ish directions, modest covariance.
    function automatic t_pair random_pair();
        t_pair p;
        int shape;
        shape = $urandom_range(99);
        p.source_point = VEC3_W'({$urandom, $urandom});
        p.target_point = VEC3_W'({$urandom, $urandom});
        p.source_dir_2d = $urandom;
        p.target_dir = VEC3_W'({$urandom, $urandom});
        p.plane_rot_col0 = VEC3_W'({$urandom, $urandom});
        p.plane_rot_col1 = VEC3_W'({$urandom, $urandom});
        p.concentration = 16'($urandom);
        p.inv_cov_diag = VEC3_W'({$urandom, $urandom});
        p.inv_cov_offdiag = VEC3_W'({$urandom, $urandom});
        p.first_sample = ($urandom_range(15) == 0);
        if (shape < 70) begin
            // Close matches with rotation and direction components within one unit.
            for (int i = 0; i < 3; i++) begin
                p.source_point[i*16 +: 16] = 16'($urandom_range(4000) - 2000);
                p.target_point[i*16 +: 16] = p.source_point[i*16 +: 16]
                                             + 16'($urandom_range(256) - 128);
                p.target_dir[i*16 +: 16]     = 16'($urandom_range(32768) - 16384);
                p.plane_rot_col0[i*16 +: 16] = 16'($urandom_range(32768) - 16384);
                p.plane_rot_col1[i*16 +: 16] = 16'($urandom_range(32768) - 16384);
                p.inv_cov_diag[i*16 +: 16]   = 16'($urandom_range(2048));
                p.inv_cov_offdiag[i*16 +: 16] = 16'($urandom_range(256) - 128);
            end
            p.source_dir_2d = {16'($urandom_range(32768) - 16384),
                               16'($urandom_range(32768) - 16384)};
            p.concentration = 16'($urandom_range(4096));
        end else if (shape < 80) begin
            // Target direction along the plane normal, projection near zero.
            p.plane_rot_col0 = {16'd0, 16'd0, q14(1.0)};
            p.plane_rot_col1 = {16'd0, q14(1.0), 16'd0};
            p.target_dir = {q14(1.0), 16'($urandom_range(64) - 32),
                            16'($urandom_range(64) - 32)};
        end
        return p;
    endfunction

    // Result side: random stalls, a long hold-off counted here, then field checks.
    initial begin
        err_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                err_bus.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                err_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && err_bus.valid && err_bus.ready) begin
                t_match_err got, want;
                got.sample_error   = err_bus.sample_error;
                got.total_error    = err_bus.total_error;
                got.dir_degenerate = err_bus.dir_degenerate;
                if (expected_errs.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    fail_count++;
                end else begin
                    want = expected_errs.pop_front();
                    if (got.sample_error !== want.sample_error) begin
                        $display("%0t: sample_error expected %h actual %h", $realtime,
                                 want.sample_error, got.sample_error);
                        fail_count++;
                    end
                    if (got.total_error !== want.total_error) begin
                        $display("%0t: total_error expected %h actual %h", $realtime,
                                 want.total_error, got.total_error);
                        fail_count++;
                    end
                    if (got.dir_degenerate !== want.dir_degenerate) begin
                        $display("%0t: dir_degenerate expected %b actual %b", $realtime,
                                 want.dir_degenerate, got.dir_degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Directed table; rows with a typed result are checked against it directly.
    typedef struct {
        t_pair      pair;
        bit         has_known;
        t_match_err known;
    } t_row;

    t_row directed[$];

    task automatic add_row(input t_pair p, input bit known_valid, input t_match_err k);
        t_row r;
        r.pair = p;
        r.has_known = known_valid;
        r.known = k;
        directed.push_back(r);
    endtask

    function automatic t_pair base_pair();
        t_pair p;
        p = '0;
        p.plane_rot_col0 = {16'd0, 16'd0, q14(1.0)};
        p.plane_rot_col1 = {16'd0, q14(1.0), 16'd0};
        p.target_dir     = {16'd0, 16'd0, q14(1.0)};
        p.source_dir_2d  = {16'd0, q14(1.0)};
        return p;
    endfunction

    initial begin
        t_pair p;
        t_match_err k;
        t_match_err chk;
        logic [TOT_W-1:0] saved_total;
        int n_items;
        fail_count = 0;
        rx_stall_pct = 19;
        tx_stall_pct = 19;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pair_bus.valid = 1'b0;
        pair_bus.source_point = '0; pair_bus.source_dir_2d = '0;
        pair_bus.target_point = '0; pair_bus.target_dir = '0;
        pair_bus.plane_rot_col0 = '0; pair_bus.plane_rot_col1 = '0;
        pair_bus.concentration = '0; pair_bus.inv_cov_diag = '0;
        pair_bus.inv_cov_offdiag = '0; pair_bus.first_sample = 1'b0;
        pred_min_norm = MIN_NORM_RST;
        pred_total = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-zero pair right after reset: zero projection, degenerate, zero error.
        p = '0;
        k = '{sample_error: '0, total_error: '0, dir_degenerate: 1'b1};
        add_row(p, 1'b1, k);
        // Aligned unit directions with k = 1.0 and no offset: error exactly zero.
        p = base_pair();
        p.concentration = 16'h0100;
        p.first_sample = 1'b1;
        k = '{sample_error: '0, total_error: '0, dir_degenerate: 1'b0};
        add_row(p, 1'b1, k);
        // Opposed directions: k*(1-(-1)) = 2.0 with k = 1.0.
        p = base_pair();
        p.concentration = 16'h0100;
        p.source_dir_2d = {16'd0, q14(-1.0)};
        k = '{sample_error: 32'h0002_0000, total_error: 48'h2_0000, dir_degenerate: 1'b0};
        add_row(p, 1'b1, k);
        // Degenerate with k = 1.0: error is exactly k.
        p = '0;
        p.concentration = 16'h0100;
        p.first_sample = 1'b1;
        k = '{sample_error: 32'h0001_0000, total_error: 48'h1_0000, dir_degenerate: 1'b1};
        add_row(p, 1'b1, k);
        // Field extremes: full positive and full negative words everywhere.
        p = {$bits(t_pair){1'b1}};
        add_row(p, 1'b0, k);
        p = {{8{16'h7FFF}}, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             16'h7FFF, 1'b0};
        add_row(p, 1'b0, k);
        p = {{8{16'h8000}}, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
             16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
             16'h8000, 1'b1};
        add_row(p, 1'b0, k);
        // Large offset with maximal covariance saturates the sample error.
        p = base_pair();
        p.source_point = {3{16'h8000}};
        p.target_point = {3{16'h7FFF}};
        p.inv_cov_diag = {3{16'h7FFF}};
        p.inv_cov_offdiag = {3{16'h7FFF}};
        p.concentration = 16'hFFFF;
        k = '{sample_error: 32'hFFFF_FFFF, total_error: 48'hFFFF_FFFF, dir_degenerate: 1'b0};
        add_row(p, 1'b0, k);
        // Negative definite covariance: the sum goes negative and clamps to zero.
        p = base_pair();
        p.target_point = {16'd0, 16'd0, 16'd640};
        p.inv_cov_diag = {3{16'h8000}};
        add_row(p, 1'b0, k);
        // Source direction longer than one unit drives the orientation term negative.
        p = base_pair();
        p.concentration = 16'hFFFF;
        p.source_dir_2d = {16'd0, 16'h7FFF};
        add_row(p, 1'b0, k);
        // Short projection just under and exactly at the reset threshold.
        p = base_pair();
        p.concentration = 16'h0100;
        p.target_dir = {q14(1.0), 16'd0, 16'd15};
        add_row(p, 1'b0, k);
        p.target_dir = {q14(1.0), 16'd0, 16'd16};
        add_row(p, 1'b0, k);
        // Off-diagonal and diagonal terms together, with a diagonal offset.
        p = base_pair();
        p.target_point = {16'd64, 16'hFFC0, 16'd128};
        p.inv_cov_offdiag = {16'h0100, 16'hFF00, 16'h0080};
        p.inv_cov_diag = {16'h0200, 16'h0200, 16'h0200};
        add_row(p, 1'b0, k);

        foreach (directed[i]) begin
            // Undo the predictor's state change; send_pair predicts again.
            saved_total = pred_total;
            chk = predict_match_err(directed[i].pair);
            pred_total = saved_total;
            if (directed[i].has_known && chk !== directed[i].known) begin
                $display("%0t: directed row %0d expected %h actual %h", $realtime, i,
                         directed[i].known, chk);
                fail_count++;
            end
            send_pair(directed[i].pair);
        end
        drop_valid();
        drain_results();

        // Four saturated sample errors in a row accumulate in the running total.
        p = base_pair();
        p.source_point = {3{16'h8000}};
        p.target_point = {3{16'h7FFF}};
        p.inv_cov_diag = {3{16'h7FFF}};
        p.inv_cov_offdiag = {3{16'h7FFF}};
        p.first_sample = 1'b1;
        send_pair(p);
        p.first_sample = 1'b0;
        for (int i = 0; i < 3; i++) send_pair(p);
        drop_valid();
        drain_results();

        // Random phases across several thresholds, the extremes among them.
        n_items = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_min_norm(32'd0);
                1: write_min_norm(32'h3FFF);
                2: write_min_norm(32'hFFFF_C010);
                3: write_min_norm(32'($urandom_range(16383)));
                4: begin
                    write_unused(32'd5);
                    write_min_norm(32'd16);
                end
                default: write_min_norm(32'($urandom_range(2000)));
            endcase
            for (int i = 0; i < 220; i++) begin
                // Quiet stretch with no idling on either side.
                if (phase == 2 && i == 40) begin
                    rx_stall_pct = 0;
                    tx_stall_pct = 0;
                end
                if (phase == 2 && i == 120) begin
                    rx_stall_pct = 19;
                    tx_stall_pct = 19;
                end
                // Long receiver hold-off while items keep coming.
                if (phase == 3 && i == 50) hold_cycles = 400;
                // Sender pauses until everything has come back.
                if (phase == 4 && i == 100) begin
                    drop_valid();
                    while (expected_errs.size() != 0) @(posedge i_clk);
                end
                send_pair(random_pair());
                n_items++;
            end
            drop_valid();
            drain_results();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/opme_pkg.sv
rtl/opme_if.sv
rtl/opme_cfg.sv
rtl/opme_sqdiv.sv
rtl/oriented_point_match_error.sv
tb/opme_tb_if.sv
tb/tb.sv
